/* src/btt_pkg.sv */
// ----------------------------------------------------------------------------
// btt_pkg
// Shared constants, register codes and types of the batched tile transpose.
// ----------------------------------------------------------------------------
package btt_pkg;

	localparam int LANES_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;

	// Stream payload layout: 16 word slots of 32 bits, index above them.
	localparam int SLOT_PITCH = 32;
	localparam int MAX_SLOTS  = 16;
	localparam int INDEX_W    = 32;
	localparam int S_DATA_W   = SLOT_PITCH * MAX_SLOTS;
	localparam int M_DATA_W   = S_DATA_W + INDEX_W;

	// Dimension registers.
	localparam int DIM_W       = 13;
	localparam int MAX_DIM     = 4096;
	localparam int BATCH_W     = 12;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_BATCH_COUNT  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd2;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_MUL1,
		ST_MUL2,
		ST_EMIT
	} btt_state_t;

	// Control from the sequencer to the output register.
	typedef struct packed {
		logic               load;
		logic               tile_last;
		logic               job_last;
		logic [INDEX_W-1:0] index;
	} btt_emit_t;

endpackage

/* src/btt_lane.sv */
// ----------------------------------------------------------------------------
// btt_lane
// One tile row: holds the row's words, returns one column word per read.
// ----------------------------------------------------------------------------
module btt_lane import btt_pkg::*; #(
	parameter int LANES     = LANES_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	localparam int SLOT_W   = $clog2(LANES)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [LANES*WORD_BITS-1:0] wr_words,
	input  logic                       rd_en,
	input  logic [SLOT_W-1:0]          rd_col,
	output logic [WORD_BITS-1:0]       rd_word_q
);

	logic [WORD_BITS-1:0] row_q [LANES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int k = 0; k < LANES; k++) begin
				row_q[k] <= wr_words[k*WORD_BITS +: WORD_BITS];
			end
		end
		if (rd_en) begin
			rd_word_q <= row_q[rd_col];
		end
	end

endmodule

/* src/btt_ctrl.sv */
// ----------------------------------------------------------------------------
// btt_ctrl
// Dimension registers, position counters, output index and drain sequencer.
// ----------------------------------------------------------------------------
module btt_ctrl import btt_pkg::*; #(
	parameter int LANES   = LANES_DEF,
	localparam int SLOT_W = $clog2(LANES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]       cfg_data,
	output logic                   cfg_ready,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   out_free,
	output logic                   wr_en,
	output logic [SLOT_W-1:0]      wr_slot,
	output logic [SLOT_W-1:0]      rd_col,
	output btt_emit_t              emit
);

	localparam int MAX_CHUNKS = (MAX_DIM + LANES - 1) / LANES;
	localparam int CHUNK_W    = $clog2(MAX_CHUNKS);
	localparam int MAX_RCH    = MAX_DIM / LANES;
	localparam int RCH_W      = $clog2(MAX_RCH + 1);
	localparam int DIV_K      = 17;
	localparam int DIV_RECIP  = ((1 << DIV_K) + LANES - 1) / LANES;
	localparam int PROD_W     = DIM_W + DIV_K;
	localparam int COL_W      = DIM_W + 1;
	localparam int P1_W       = BATCH_W + COL_W;
	localparam int RST_RCH    = 16 / LANES;
	localparam int RST_CHUNKS = (16 + LANES - 1) / LANES;

	// Exact floor(v / LANES) for 13-bit v by reciprocal multiply.
	function automatic logic [DIM_W-1:0] div_l(input logic [DIM_W-1:0] v);
		logic [PROD_W-1:0] p;
		p = PROD_W'(v) * PROD_W'(DIV_RECIP);
		return p[DIV_K +: DIM_W];
	endfunction

	btt_state_t state_q, state_d;

	// derived dimensions
	logic [DIM_W-1:0]   batches_q, cols_q, chunks_q, rows_q;
	logic [RCH_W-1:0]   row_chunks_q;
	// position
	logic [BATCH_W-1:0] batch_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [BATCH_W-1:0] row_q;
	logic [RCH_W-1:0]   rchunk_q;
	logic [SLOT_W-1:0]  slot_q;
	// tile snapshot and drain
	logic [BATCH_W-1:0] snap_batch_q;
	logic [COL_W-1:0]   snap_base_q;
	logic [RCH_W-1:0]   snap_rch_q;
	logic               last_tile_q;
	logic [SLOT_W-1:0]  last_c_q, col_q;
	logic [P1_W-1:0]    p1_q;
	logic [INDEX_W-1:0] idx_q;

	logic               cfg_wr, acc, tile_end, has_cols, col_done;
	logic [DIM_W-1:0]   cfg_dim, cfg_rq, cfg_rch, cfg_chunks;
	logic [DIM_W-1:0]   row_inc, chunk_inc, batch_inc;
	logic               row_wrap, chunk_wrap, batch_wrap;
	logic [COL_W-1:0]   base_col, col_rem;
	logic [SLOT_W-1:0]  last_c;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		cfg_dim = cfg_data;
		if (cfg_data == '0) begin
			cfg_dim = DIM_W'(1);
		end else if (cfg_data > DIM_W'(MAX_DIM)) begin
			cfg_dim = DIM_W'(MAX_DIM);
		end
		cfg_rq  = div_l(cfg_data);
		cfg_rch = cfg_rq;
		if (cfg_rq == '0) begin
			cfg_rch = DIM_W'(1);
		end else if (cfg_rq > DIM_W'(MAX_RCH)) begin
			cfg_rch = DIM_W'(MAX_RCH);
		end
		cfg_chunks = div_l(cfg_dim + DIM_W'(LANES - 1));
	end

	assign acc        = in_valid && in_ready;
	assign tile_end   = slot_q == SLOT_W'(LANES - 1);
	assign row_inc    = DIM_W'(row_q) + DIM_W'(1);
	assign chunk_inc  = DIM_W'(chunk_q) + DIM_W'(1);
	assign batch_inc  = DIM_W'(batch_q) + DIM_W'(1);
	assign row_wrap   = row_inc >= rows_q;
	assign chunk_wrap = chunk_inc >= chunks_q;
	assign batch_wrap = batch_inc >= batches_q;

	// columns of this chunk that fall inside the column count
	always_comb begin
		base_col = COL_W'(chunk_q) * COL_W'(LANES);
		has_cols = base_col < COL_W'(cols_q);
		col_rem  = COL_W'(cols_q) - base_col - COL_W'(1);
		last_c   = col_rem[SLOT_W-1:0];
		if (col_rem >= COL_W'(LANES - 1)) begin
			last_c = SLOT_W'(LANES - 1);
		end
	end

	assign col_done = col_q == last_c_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (acc && tile_end && has_cols) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free && col_done) begin
					state_d = ST_FILL;
				end
			end
			default: state_d = ST_FILL;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		emit.load      = 1'b0;
		case (state_q)
			ST_FILL: in_ready  = 1'b1;
			ST_EMIT: emit.load = out_free;
			default: ;
		endcase
		emit.tile_last = col_done;
		emit.job_last  = col_done && last_tile_q;
		emit.index     = idx_q;
	end

	assign wr_en   = acc;
	assign wr_slot = slot_q;
	assign rd_col  = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_FILL;
			batches_q    <= DIM_W'(1);
			cols_q       <= DIM_W'(16);
			chunks_q     <= DIM_W'(RST_CHUNKS);
			row_chunks_q <= RCH_W'(RST_RCH);
			rows_q       <= DIM_W'(RST_RCH * LANES);
			batch_q      <= '0;
			chunk_q      <= '0;
			row_q        <= '0;
			rchunk_q     <= '0;
			slot_q       <= '0;
			col_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				case (cfg_index)
					REG_BATCH_COUNT:  batches_q <= cfg_dim;
					REG_ROW_COUNT: begin
						row_chunks_q <= RCH_W'(cfg_rch);
						rows_q       <= DIM_W'(cfg_rch * DIM_W'(LANES));
					end
					REG_COLUMN_COUNT: begin
						cols_q   <= cfg_dim;
						chunks_q <= cfg_chunks;
					end
					default: ;
				endcase
			end
			if (acc) begin
				if (row_wrap) begin
					row_q    <= '0;
					rchunk_q <= '0;
					slot_q   <= '0;
					if (chunk_wrap) begin
						chunk_q <= '0;
						batch_q <= batch_wrap ? '0 : batch_inc[BATCH_W-1:0];
					end else begin
						chunk_q <= chunk_inc[CHUNK_W-1:0];
					end
				end else begin
					row_q <= row_inc[BATCH_W-1:0];
					if (tile_end) begin
						slot_q   <= '0;
						rchunk_q <= rchunk_q + RCH_W'(1);
					end else begin
						slot_q <= slot_q + SLOT_W'(1);
					end
				end
				if (tile_end) begin
					col_q <= '0;
				end
			end
			if (emit.load) begin
				col_q <= col_q + SLOT_W'(1);
			end
		end
	end

	// tile snapshot and index arithmetic
	always_ff @(posedge clk) begin
		if (acc && tile_end) begin
			snap_batch_q <= batch_q;
			snap_base_q  <= base_col;
			snap_rch_q   <= rchunk_q;
			last_tile_q  <= row_wrap && chunk_wrap && batch_wrap;
			last_c_q     <= last_c;
		end
		case (state_q)
			ST_MUL1: p1_q <= P1_W'(snap_batch_q) * P1_W'(cols_q) + P1_W'(snap_base_q);
			ST_MUL2: idx_q <= INDEX_W'(p1_q) * INDEX_W'(row_chunks_q) + INDEX_W'(snap_rch_q);
			ST_EMIT: begin
				if (emit.load) begin
					idx_q <= idx_q + INDEX_W'(row_chunks_q);
				end
			end
			default: ;
		endcase
	end

endmodule

/* src/batched_tile_transpose_core.sv */
// ----------------------------------------------------------------------------
// batched_tile_transpose_core
// Transposes the last two axes of a batch of matrices, one LANES x LANES
// tile at a time, with a row lane per tile row.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake           payload
//  -------   ---   ---------           -------
//  s_*       in    s_tvalid/s_tready   s_tdata: input row, words 0..15
//  m_*       out   m_tvalid/m_tready   m_tdata: column words, out_index;
//                                      m_tlast: tile_last; m_tuser: job_last
//  cfg_*     in    cfg_valid/cfg_ready cfg_index, cfg_data
//
//  Flow: rows are taken one a cycle while a tile fills. After the row that
//  closes a tile the input stalls for the index arithmetic (two registered
//  multiplies) and then while the tile's columns are emitted one by one as
//  the output frees; a tile whose columns all lie past the column count
//  emits nothing and adds no stall. The single tile buffer in the row lanes
//  causes this stall.
//  Reset: arst_n clears counters and loads default dimensions (1 batch,
//  16 rows, 16 columns). A stalled m_tready holds the output register and the
//  drain, and with it the input.
// ----------------------------------------------------------------------------
module batched_tile_transpose_core import btt_pkg::*; #(
	parameter int LANES     = LANES_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input rows
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [S_DATA_W-1:0]    s_tdata,   // words_0_1, words_2_3, .. words_14_15
	// output columns
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_DATA_W-1:0]    m_tdata,   // out_words_0_1 .. out_words_14_15, out_index
	output logic                   m_tlast,   // tile_last
	output logic                   m_tuser,   // job_last
	// register writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]       cfg_data
);

	localparam int SLOT_W = $clog2(LANES);

	logic                       wr_en;
	logic [SLOT_W-1:0]          wr_slot, rd_col;
	logic                       out_free;
	btt_emit_t                  emit;
	logic [LANES*WORD_BITS-1:0] wr_words;
	logic [WORD_BITS-1:0]       lane_word [LANES];

	logic                       m_tvalid_q, m_tlast_q, m_tuser_q;
	logic [INDEX_W-1:0]         index_q;

	// output register frees when empty or taken this cycle
	assign out_free = !m_tvalid_q || m_tready;

	btt_ctrl #(
		.LANES (LANES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_free  (out_free),
		.wr_en     (wr_en),
		.wr_slot   (wr_slot),
		.rd_col    (rd_col),
		.emit      (emit)
	);

	// Word k of a row sits at a 32-bit slot; only its low WORD_BITS count.
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			wr_words[k*WORD_BITS +: WORD_BITS] = s_tdata[k*SLOT_PITCH +: WORD_BITS];
		end
	end

	// Lane r holds tile row r; its read register is output word r.
	for (genvar r = 0; r < LANES; r++) begin : g_lane
		btt_lane #(
			.LANES     (LANES),
			.WORD_BITS (WORD_BITS)
		) u_lane (
			.clk       (clk),
			.wr_en     (wr_en && (wr_slot == SLOT_W'(r))),
			.wr_words  (wr_words),
			.rd_en     (emit.load),
			.rd_col    (rd_col),
			.rd_word_q (lane_word[r])
		);
	end

	// Side fields of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			m_tlast_q <= emit.tile_last;
			m_tuser_q <= emit.job_last;
			index_q   <= emit.index;
		end
	end

	// Merge the lane words into one output vector; unused bits stay zero.
	always_comb begin
		m_tdata = '0;
		for (int r = 0; r < LANES; r++) begin
			m_tdata[r*SLOT_PITCH +: WORD_BITS] = lane_word[r];
		end
		m_tdata[S_DATA_W +: INDEX_W] = index_q;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for batched_tile_transpose_core. Rows go in on the
// s_* stream and are mirrored into a local tile store; each closing row of a
// tile queues the transposed columns it should produce. Every m_* request
// is checked field by field against the oldest queued column. Dimensions
// are rewritten between phases only, once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb import btt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TILE             = LANES_DEF;
	localparam int HALF_PERIOD      = 5;
	localparam int RESET_CYCLES     = 12;
	// Wait for the closing row of a tile to drain: both multiplies and the column emits, padded.
	localparam int DRAIN_CYCLES     = 2 * TILE + 16;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int RANDOM_ITEMS     = 150;
	localparam int PHASE_MAX_ITEMS  = 160;
	localparam int CYCLE_LIMIT      = 200000;

	// One expected output column.
	typedef struct packed {
		logic [S_DATA_W-1:0] words;
		logic [INDEX_W-1:0]  index;
		logic                tile_last;
		logic                job_last;
	} column_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [S_DATA_W-1:0]    s_tdata   = '0;   // words_0_1 .. words_14_15
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [M_DATA_W-1:0]    m_tdata;          // out_words_0_1 .. out_words_14_15, out_index
	logic                   m_tlast;          // tile_last
	logic                   m_tuser;          // job_last
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_BATCH_COUNT;
	logic [DIM_W-1:0]       cfg_data  = '0;

	// Random idle bursts on both sides; cleared for the closing stretch.
	bit idle_on   = 1'b1;
	// Raised by the back-pressure test, dropped by the sink when done.
	bit long_hold = 1'b0;

	int unsigned err_count   = 0;
	int unsigned cycle_count = 0;

	// Local copy of the block: tile store, job counters, dimension registers.
	logic [SLOT_PITCH-1:0] tile_words [TILE][TILE];
	int unsigned           row_pos     = 0;
	int unsigned           chunk_pos   = 0;
	int unsigned           batch_pos   = 0;
	logic [DIM_W-1:0]      reg_batches = 13'd1;
	logic [DIM_W-1:0]      reg_rows    = 13'd16;
	logic [DIM_W-1:0]      reg_cols    = 13'd16;

	column_t pending_columns [$];

	batched_tile_transpose_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---- dimension arithmetic --------------------------------------------

	// batch and column counts live in [1, MAX_DIM]
	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	// row count: low bits dropped, then held to [TILE, MAX_DIM rounded down]
	function automatic int unsigned rows_used();
		int unsigned r;
		int unsigned top;
		r   = reg_rows - (reg_rows % TILE);
		top = MAX_DIM - (MAX_DIM % TILE);
		if (r < TILE)
			r = TILE;
		if (r > top)
			r = top;
		return r;
	endfunction

	// Rows left until the current job wraps; a guess when a dimension change
	// has left a counter out of range.
	function automatic int unsigned items_to_job_end();
		int unsigned batches;
		int unsigned chunks;
		int unsigned rows;
		batches = clamp_dim(reg_batches);
		chunks  = (clamp_dim(reg_cols) + TILE - 1) / TILE;
		rows    = rows_used();
		if (batch_pos >= batches || chunk_pos >= chunks || row_pos >= rows)
			return rows;
		return ((batches - 1 - batch_pos) * chunks + (chunks - 1 - chunk_pos)) * rows
			+ (rows - row_pos);
	endfunction

	// ---- predictor -------------------------------------------------------

	// Store one accepted row; on the closing row of a tile queue one column
	// per tile column still inside the column count.
	task automatic predict_columns(input logic [S_DATA_W-1:0] row);
		int unsigned batches;
		int unsigned cols;
		int unsigned rows;
		int unsigned chunks;
		int unsigned row_chunks;
		int unsigned slot;
		int unsigned col;
		int          last_c;
		bit          last_tile;
		logic [63:0] idx;
		column_t     expc;
		batches    = clamp_dim(reg_batches);
		cols       = clamp_dim(reg_cols);
		rows       = rows_used();
		chunks     = (cols + TILE - 1) / TILE;
		row_chunks = rows / TILE;
		slot       = row_pos % TILE;

		for (int k = 0; k < TILE; k++)
			tile_words[slot][k] = row[SLOT_PITCH*k +: SLOT_PITCH];

		if (slot == TILE - 1) begin
			last_tile = (batch_pos + 1 >= batches) && (chunk_pos + 1 >= chunks) &&
				(row_pos + 1 >= rows);
			last_c = -1;
			for (int c = 0; c < TILE; c++)
				if (chunk_pos * TILE + c < cols)
					last_c = c;
			for (int c = 0; c < TILE; c++) begin
				col = chunk_pos * TILE + c;
				if (col < cols) begin
					expc.words = '0;
					// output word r is word c of tile row r
					for (int r = 0; r < TILE; r++)
						expc.words[SLOT_PITCH*r +: SLOT_PITCH] = tile_words[r][c];
					idx = 64'(batch_pos) * 64'(cols) * 64'(row_chunks) +
						64'(col) * 64'(row_chunks) + 64'(row_pos / TILE);
					expc.index     = idx[INDEX_W-1:0];
					expc.tile_last = (c == last_c);
					expc.job_last  = (c == last_c) && last_tile;
					pending_columns.push_back(expc);
				end
			end
		end

		// counters out of range after a dimension change wrap on advance
		row_pos++;
		if (row_pos >= rows) begin
			row_pos = 0;
			chunk_pos++;
			if (chunk_pos >= chunks) begin
				chunk_pos = 0;
				batch_pos++;
				if (batch_pos >= batches)
					batch_pos = 0;
			end
		end
	endtask

	// ---- checker ---------------------------------------------------------

	always @(posedge clk) begin : check_columns
		column_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_columns.size() == 0) begin
				$error("unexpected column request, out_index %0d",
					m_tdata[M_DATA_W-1:S_DATA_W]);
				err_count++;
			end else begin
				want = pending_columns.pop_front();
				for (int i = 0; i < TILE / 2; i++)
					if (m_tdata[64*i +: 64] !== want.words[64*i +: 64]) begin
						$error("out_words_%0d_%0d: expected %h, actual %h", 2*i, 2*i+1,
							want.words[64*i +: 64], m_tdata[64*i +: 64]);
						err_count++;
					end
				if (m_tdata[M_DATA_W-1:S_DATA_W] !== want.index) begin
					$error("out_index: expected %0d, actual %0d", want.index,
						m_tdata[M_DATA_W-1:S_DATA_W]);
					err_count++;
				end
				if (m_tlast !== want.tile_last) begin
					$error("tile_last: expected %0b, actual %0b", want.tile_last, m_tlast);
					err_count++;
				end
				if (m_tuser !== want.job_last) begin
					$error("job_last: expected %0b, actual %0b", want.job_last, m_tuser);
					err_count++;
				end
			end
		end
	end

	// ---- output side: ready with random stalls and one long hold ---------

	initial begin : drive_sink
		int unsigned gap;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				// hold off long enough for the tile buffer to fill and stall s_*
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
				m_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				gap = $urandom_range(1, 10);
				repeat (gap) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---- stimulus helpers ------------------------------------------------

	// Mostly random words, with some all-zero and all-one words mixed in.
	function automatic logic [S_DATA_W-1:0] random_row();
		logic [S_DATA_W-1:0] row;
		for (int k = 0; k < MAX_SLOTS; k++)
			case ($urandom_range(0, 7))
				0:       row[SLOT_PITCH*k +: SLOT_PITCH] = '0;
				1:       row[SLOT_PITCH*k +: SLOT_PITCH] = '1;
				default: row[SLOT_PITCH*k +: SLOT_PITCH] = $urandom;
			endcase
		return row;
	endfunction

	// One row request; tvalid stays up for a following row unless a gap lands.
	task automatic send_row(input logic [S_DATA_W-1:0] row);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= row;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_columns(row);
	endtask

	// Block is idle once every queued column is out and the pipe has drained.
	task automatic settle();
		while (pending_columns.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic finish_burst();
		s_tvalid <= 1'b0;
		settle();
	endtask

	task automatic send_rows(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			send_row(random_row());
		finish_burst();
	endtask

	// All three dimension registers, back to back; block must be idle.
	task automatic set_dims(input logic [DIM_W-1:0] b, input logic [DIM_W-1:0] r,
			input logic [DIM_W-1:0] c);
		logic [DIM_W-1:0]       vals [3];
		logic [CFG_INDEX_W-1:0] regs [3];
		vals = '{b, r, c};
		regs = '{REG_BATCH_COUNT, REG_ROW_COUNT, REG_COLUMN_COUNT};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid   <= 1'b0;
		reg_batches = b;
		reg_rows    = r;
		reg_cols    = c;
	endtask

	// ---- tests -----------------------------------------------------------

	// Reset dimensions (1 x 16 x 16): one tile, whole job. Rows carry flat,
	// alternating and position-tagged words so a misplaced word shows up.
	task automatic test_default_tile();
		logic [S_DATA_W-1:0] row;
		for (int r = 0; r < TILE; r++) begin
			case (r)
				0:       row = '0;
				1:       row = '1;
				2:       row = {MAX_SLOTS{32'hAAAA_AAAA}};
				3:       row = {MAX_SLOTS{32'h5555_5555}};
				default: for (int k = 0; k < MAX_SLOTS; k++)
					row[SLOT_PITCH*k +: SLOT_PITCH] = {8'(r), 8'(k), 16'($urandom)};
			endcase
			send_row(row);
		end
		finish_burst();
	endtask

	// Clamped, oversize and unaligned dimensions, each followed by a burst of
	// rows, some leaving a job partial so later phases start with counters past
	// the new limits; the last two phases sit on a column chunk past the count and emit nothing.
	task automatic test_dimension_extremes();
		set_dims(13'd0, 13'd0, 13'd0);
		send_rows(2 * TILE);
		set_dims(13'd8191, 13'd8191, 13'd8191);
		send_rows(2 * TILE);
		set_dims(13'd4096, 13'd17, 13'd4095);
		send_rows(3 * TILE);
		set_dims(13'd4095, 13'd4095, 13'd17);
		send_rows(2 * TILE);
		set_dims(13'd1, 13'd4096, 13'd1);
		send_rows(2 * TILE);
	endtask

	// Mostly complete jobs with random small dimensions and random data,
	// some cut short to leave a job half done across a dimension change.
	task automatic test_random_jobs();
		int unsigned sent;
		int unsigned n;
		logic [DIM_W-1:0] b;
		logic [DIM_W-1:0] r;
		logic [DIM_W-1:0] c;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			b = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 3));
			r = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, TILE - 1)) :
				13'(TILE * $urandom_range(1, 3) + $urandom_range(0, TILE - 1));
			c = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 40));
			set_dims(b, r, c);
			n = items_to_job_end();
			if (n > PHASE_MAX_ITEMS || $urandom_range(0, 4) == 0)
				n = $urandom_range(1, 40);
			send_rows(n);
			sent += n;
		end
	endtask

	// Output held off for a long stretch while rows keep coming.
	task automatic test_back_pressure();
		set_dims(13'd2, 13'd32, 13'd16);
		long_hold = 1'b1;
		send_rows(4 * TILE);
	endtask

	// Closing stretch with no idle cycles on either side.
	task automatic test_steady_stream();
		idle_on = 1'b0;
		set_dims(13'd1, 13'd16, 13'd32);
		send_rows(items_to_job_end());
		send_rows(4 * TILE);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_tile();
		test_dimension_extremes();
		test_random_jobs();
		test_back_pressure();
		test_steady_stream();

		settle();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
